// ----- rtl/core/asp_pkg.sv -----
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types, lamp codes, register indexes and the fixed-cycle tables of the
// actuated signal phase controller.
// ----------------------------------------------------------------------------
package asp_pkg;

   // Default depth of the request ring
   localparam int QUEUE_DEPTH_DEF = 8;

   // Timing and register widths
   localparam int TICK_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int LAMP_W  = 6;
   localparam int MV_W    = 2;
   localparam int STEP_W  = 4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_DEFAULT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTEND_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEARANCE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP           = 3'd5;

   // Register reset values
   localparam logic [TICK_W-1:0] GREEN_DEFAULT_RST = 8'd10;
   localparam logic [TICK_W-1:0] EXTEND_STEP_RST   = 8'd2;
   localparam logic [TICK_W-1:0] GREEN_LIMIT_RST   = 8'd24;
   localparam logic [TICK_W-1:0] YELLOW_RST        = 8'd2;
   localparam logic [TICK_W-1:0] CLEARANCE_RST     = 8'd2;
   localparam logic [TICK_W-1:0] GAP_RST           = 8'd1;

   // Lamp words: 5 left green, 4 left yellow, 3 left red, 2 fwd green,
   // 1 fwd yellow, 0 fwd red
   localparam logic [LAMP_W-1:0] LAMP_RED         = 6'b001001;
   localparam logic [LAMP_W-1:0] LAMP_LEFT_GREEN  = 6'b100001;
   localparam logic [LAMP_W-1:0] LAMP_LEFT_YELLOW = 6'b010001;
   localparam logic [LAMP_W-1:0] LAMP_FWD_GREEN   = 6'b001100;
   localparam logic [LAMP_W-1:0] LAMP_FWD_YELLOW  = 6'b001010;

   // Fixed cycle: thirteen steps, major road first
   localparam logic [STEP_W-1:0] FIXED_LAST = 4'd12;

   // Shared arithmetic unit
   typedef enum logic {
      ALU_ADD,
      ALU_GE
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [TICK_W-1:0] a;
      logic [TICK_W-1:0] b;
   } alu_req_type;

   function automatic logic [LAMP_W-1:0] fixed_major(input logic [STEP_W-1:0] s);
      logic [LAMP_W-1:0] w;
      case (s)
         4'd1:    w = LAMP_LEFT_GREEN;
         4'd2:    w = LAMP_LEFT_YELLOW;
         4'd4:    w = LAMP_FWD_GREEN;
         4'd5:    w = LAMP_FWD_YELLOW;
         default: w = LAMP_RED;
      endcase
      return w;
   endfunction

   function automatic logic [LAMP_W-1:0] fixed_minor(input logic [STEP_W-1:0] s);
      logic [LAMP_W-1:0] w;
      case (s)
         4'd7:    w = LAMP_LEFT_GREEN;
         4'd8:    w = LAMP_LEFT_YELLOW;
         4'd10:   w = LAMP_FWD_GREEN;
         4'd11:   w = LAMP_FWD_YELLOW;
         default: w = LAMP_RED;
      endcase
      return w;
   endfunction

   function automatic logic [TICK_W-1:0] fixed_len(input logic [STEP_W-1:0] s);
      logic [TICK_W-1:0] n;
      case (s)
         4'd1, 4'd4, 4'd7, 4'd10: n = 8'd10;
         4'd2, 4'd5, 4'd8, 4'd11: n = 8'd2;
         4'd12:                   n = 8'd2;
         default:                 n = 8'd4;
      endcase
      return n;
   endfunction

endpackage

// ----- rtl/core/asp_ram.sv -----
// ----------------------------------------------------------------------------
// asp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module asp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/asp_alu.sv -----
// ----------------------------------------------------------------------------
// asp_alu
// Shared 8-bit adder and comparator used by the sequencer for timers,
// green extension and limit checks.
// ----------------------------------------------------------------------------
module asp_alu (
   input  asp_pkg::alu_req_type      alu_req,
   output logic [asp_pkg::TICK_W:0]  alu_res
);

   import asp_pkg::*;

   always_comb begin
      unique case (alu_req.op)
         ALU_ADD: alu_res = {1'b0, alu_req.a} + {1'b0, alu_req.b};
         ALU_GE:  alu_res = {{TICK_W{1'b0}}, (alu_req.a >= alu_req.b)};
         default: alu_res = '0;
      endcase
   end

endmodule

// ----- rtl/core/actuated_signal_phase_controller_unit.sv -----
// ----------------------------------------------------------------------------
// actuated_signal_phase_controller_unit
// Actuated signal controller for a major/minor road crossing with a request
// ring, green extension and a fixed-cycle fallback sequence.
// ----------------------------------------------------------------------------
// Each accepted word is either a tick or a detector request for one of
// four movements, and yields exactly one result word with both lamp words,
// the number of held movements and the movement being served. Work runs one
// word at a time under a small sequencer around a single shared add/compare
// unit and a ring RAM with registered read; req_tready is high only while the
// sequencer is idle. A tick only chooses a cycle while the controller is
// idle; otherwise it increments the timer and compares it with the interval,
// choosing a new cycle when a gap or the fixed cycle ends. At the end of a
// clearance it reads the new head from the RAM and, when the gap is zero,
// also chooses a cycle. A request checks the green limit, extends the green
// when it serves that movement below the limit, and enqueues the movement if
// the ring has room and the duplicate search, which reads the ring one entry
// per RAM access, does not find it held; a full ring is not searched. A
// finished result sits in the output register and the next word is taken
// while it waits; a second result stalls the sequencer until the first is
// taken. Configuration writes land at once and should be made only while no
// word is in flight. The ring has no reset and needs no clearing pass: only
// entries between head and tail are ever used.
// ----------------------------------------------------------------------------
module actuated_signal_phase_controller_unit #(
   parameter int QUEUE_DEPTH = asp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request side
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [1:0] approach, [2] fixed_cycle_switch
   input  logic                            req_tuser,  // [0] operation
   // result side
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,  // [5:0] major_lamps, [11:6] minor_lamps,
                                                       // [14:12] pending_count,
                                                       // [15] serving_valid,
                                                       // [17:16] serving_approach
   // configuration
   input  logic                            csr_we,
   input  logic [asp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [asp_pkg::TICK_W-1:0]      csr_wdata
);

   import asp_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_LIMIT,
      SQ_EXTEND,
      SQ_FULL,
      SQ_RD,
      SQ_CMP,
      SQ_ENQ,
      SQ_INC,
      SQ_TEST,
      SQ_HEAD,
      SQ_HEADCAP,
      SQ_CHOOSE,
      SQ_DONE
   } seq_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_GREEN,
      PH_YELLOW,
      PH_CLEAR,
      PH_GAP,
      PH_FIXED
   } phase_type;

   // Configuration registers
   logic [TICK_W-1:0] green_def_ff, ext_step_ff, green_lim_ff;
   logic [TICK_W-1:0] yellow_ff, clear_ff, gap_ff;

   // Sequencer and controller state
   seq_type           seq_ff, seq_in;
   phase_type         phase_ff, phase_in;
   logic              op_ff, op_in;
   logic [MV_W-1:0]   mv_ff, mv_in;
   logic              sw_ff, sw_in;
   logic [TICK_W-1:0] timer_ff, timer_in;
   logic [TICK_W-1:0] green_ff, green_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LAMP_W-1:0] major_ff, major_in;
   logic [LAMP_W-1:0] minor_ff, minor_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [MV_W-1:0]   head_mv_ff, head_mv_in;
   logic [AW-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]     scan_cnt_ff, scan_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff, rsp_data_in;

   // Ring RAM and shared unit
   logic              ram_we;
   logic [AW-1:0]     ram_raddr;
   logic [MV_W-1:0]   ram_rdata;
   alu_req_type       alu_req;
   logic [TICK_W:0]   alu_res;

   logic              serving;
   logic              sv;
   logic [TICK_W-1:0] len_sel;

   asp_ram #(
      .WIDTH (MV_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (mv_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   asp_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Lamp pair for a served movement: {minor, major}
   function automatic logic [2*LAMP_W-1:0] show(input logic [MV_W-1:0] mv, input logic yel);
      logic [LAMP_W-1:0] w;
      if (mv[0]) begin
         w = yel ? LAMP_LEFT_YELLOW : LAMP_LEFT_GREEN;
      end else begin
         w = yel ? LAMP_FWD_YELLOW : LAMP_FWD_GREEN;
      end
      return mv[1] ? {w, LAMP_RED} : {LAMP_RED, w};
   endfunction

   assign serving = (phase_ff == PH_GREEN) || (phase_ff == PH_YELLOW) ||
                    (phase_ff == PH_CLEAR);
   assign sv      = serving && (count_ff != '0);

   // Interval length of the current phase; zero lasts one tick except the gap
   always_comb begin
      case (phase_ff)
         PH_GREEN:  len_sel = (green_ff == '0)  ? 8'd1 : green_ff;
         PH_YELLOW: len_sel = (yellow_ff == '0) ? 8'd1 : yellow_ff;
         PH_CLEAR:  len_sel = (clear_ff == '0)  ? 8'd1 : clear_ff;
         PH_GAP:    len_sel = gap_ff;
         default:   len_sel = fixed_len(step_ff);
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         green_def_ff <= GREEN_DEFAULT_RST;
         ext_step_ff  <= EXTEND_STEP_RST;
         green_lim_ff <= GREEN_LIMIT_RST;
         yellow_ff    <= YELLOW_RST;
         clear_ff     <= CLEARANCE_RST;
         gap_ff       <= GAP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GREEN_DEFAULT: green_def_ff <= csr_wdata;
            CSR_EXTEND_STEP:   ext_step_ff  <= csr_wdata;
            CSR_GREEN_LIMIT:   green_lim_ff <= csr_wdata;
            CSR_YELLOW:        yellow_ff    <= csr_wdata;
            CSR_CLEARANCE:     clear_ff     <= csr_wdata;
            CSR_GAP:           gap_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: one step of the shared unit per cycle
   always_comb begin
      seq_in       = seq_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      mv_in        = mv_ff;
      sw_in        = sw_ff;
      timer_in     = timer_ff;
      green_in     = green_ff;
      step_in      = step_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      head_mv_in   = head_mv_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_cnt_in  = scan_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_raddr    = head_ff;
      alu_req      = '{op: ALU_ADD, a: timer_ff, b: 8'd1};

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (seq_ff)
         SQ_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser;
               mv_in = req_tdata[1:0];
               sw_in = req_tdata[2];
               if (req_tuser) begin
                  seq_in = SQ_LIMIT;
               end else if (phase_ff == PH_IDLE) begin
                  seq_in = SQ_CHOOSE;
               end else begin
                  seq_in = SQ_INC;
               end
            end
         end

         // request: extend the green of the served movement
         SQ_LIMIT: begin
            alu_req = '{op: ALU_GE, a: green_ff, b: green_lim_ff};
            if (sv && (head_mv_ff == mv_ff) && !alu_res[0]) begin
               seq_in = SQ_EXTEND;
            end else begin
               seq_in = SQ_FULL;
            end
         end

         SQ_EXTEND: begin
            alu_req  = '{op: ALU_ADD, a: green_ff, b: ext_step_ff};
            green_in = alu_res[TICK_W] ? 8'hFF : alu_res[TICK_W-1:0];
            seq_in   = SQ_FULL;
         end

         SQ_FULL: begin
            scan_ptr_in = head_ff;
            scan_cnt_in = '0;
            if (count_ff == CW'(QUEUE_DEPTH)) begin
               seq_in = SQ_DONE;
            end else if (count_ff == '0) begin
               seq_in = SQ_ENQ;
            end else begin
               seq_in = SQ_RD;
            end
         end

         // duplicate search, one ring entry per read
         SQ_RD: begin
            ram_raddr = scan_ptr_ff;
            seq_in    = SQ_CMP;
         end

         SQ_CMP: begin
            if (ram_rdata == mv_ff) begin
               seq_in = SQ_DONE;
            end else begin
               scan_ptr_in = wrap_inc(scan_ptr_ff);
               scan_cnt_in = CW'(scan_cnt_ff + 1'b1);
               seq_in      = (CW'(scan_cnt_ff + 1'b1) == count_ff) ? SQ_ENQ : SQ_RD;
            end
         end

         SQ_ENQ: begin
            ram_we   = 1'b1;
            tail_in  = wrap_inc(tail_ff);
            count_in = CW'(count_ff + 1'b1);
            if (count_ff == '0) begin
               head_mv_in = mv_ff;
            end
            seq_in = SQ_DONE;
         end

         // tick: advance the interval timer
         SQ_INC: begin
            alu_req  = '{op: ALU_ADD, a: timer_ff, b: 8'd1};
            timer_in = alu_res[TICK_W-1:0];
            seq_in   = SQ_TEST;
         end

         SQ_TEST: begin
            alu_req = '{op: ALU_GE, a: timer_ff, b: len_sel};
            seq_in  = SQ_DONE;
            if (alu_res[0]) begin
               timer_in = '0;
               case (phase_ff)
                  PH_GREEN: begin
                     phase_in             = PH_YELLOW;
                     {minor_in, major_in} = show(head_mv_ff, 1'b1);
                  end
                  PH_YELLOW: begin
                     phase_in = PH_CLEAR;
                     major_in = LAMP_RED;
                     minor_in = LAMP_RED;
                  end
                  PH_CLEAR: begin
                     if (count_ff != '0) begin
                        head_in  = wrap_inc(head_ff);
                        count_in = CW'(count_ff - 1'b1);
                     end
                     seq_in = SQ_HEAD;
                  end
                  PH_GAP: begin
                     seq_in = SQ_CHOOSE;
                  end
                  default: begin
                     step_in = STEP_W'(step_ff + 1'b1);
                     if (step_ff == FIXED_LAST) begin
                        seq_in = SQ_CHOOSE;
                     end else begin
                        major_in = fixed_major(STEP_W'(step_ff + 1'b1));
                        minor_in = fixed_minor(STEP_W'(step_ff + 1'b1));
                     end
                  end
               endcase
            end
         end

         // fetch the new head after a dequeue
         SQ_HEAD: begin
            ram_raddr = head_ff;
            seq_in    = SQ_HEADCAP;
         end

         SQ_HEADCAP: begin
            head_mv_in = ram_rdata;
            if (gap_ff == '0) begin
               seq_in = SQ_CHOOSE;
            end else begin
               phase_in = PH_GAP;
               seq_in   = SQ_DONE;
            end
         end

         SQ_CHOOSE: begin
            timer_in = '0;
            seq_in   = SQ_DONE;
            if (sw_ff) begin
               phase_in = PH_FIXED;
               step_in  = '0;
               major_in = fixed_major('0);
               minor_in = fixed_minor('0);
            end else if (count_ff != '0) begin
               phase_in             = PH_GREEN;
               green_in             = green_def_ff;
               {minor_in, major_in} = show(head_mv_ff, 1'b0);
            end else begin
               phase_in = PH_IDLE;
               major_in = LAMP_RED;
               minor_in = LAMP_RED;
            end
         end

         // hold until the output register is free
         SQ_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, (sv ? head_mv_ff : 2'b00), sv, count_ff[2:0],
                               minor_ff, major_ff};
               seq_in       = SQ_IDLE;
            end
         end

         default: seq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SQ_IDLE;
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         green_ff     <= GREEN_DEFAULT_RST;
         step_ff      <= '0;
         major_ff     <= LAMP_RED;
         minor_ff     <= LAMP_RED;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         green_ff     <= green_in;
         step_ff      <= step_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      mv_ff       <= mv_in;
      sw_ff       <= sw_in;
      head_mv_ff  <= head_mv_in;
      scan_ptr_ff <= scan_ptr_in;
      scan_cnt_ff <= scan_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (seq_ff == SQ_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // the ring never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("ring count exceeds depth");

   // between words, a served movement is always present in the ring
   a_serve_held: assert property (@(posedge clock) disable iff (reset)
      (serving && (seq_ff == SQ_IDLE)) |-> (count_ff != '0))
      else $error("serving with an empty ring");

   // one word at a time: no acceptance straight after another
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("word accepted while busy");

   // a new result appears only from the completion step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(seq_ff) == SQ_DONE))
      else $error("result loaded outside completion");

endmodule

// ----- verif/signal_phase_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// signal_phase_tb_pkg
// Operation and movement codes shared by the signal controller testbench and
// its checker.
// ----------------------------------------------------------------------------
package signal_phase_tb_pkg;

   typedef enum logic {
      OP_TICK,
      OP_REQUEST
   } signal_op_type;

   typedef enum logic [1:0] {
      MV_MAJOR_FWD,
      MV_MAJOR_LEFT,
      MV_MINOR_FWD,
      MV_MINOR_LEFT
   } movement_type;

endpackage

// ----- verif/signal_phase_checker.sv -----
// ----------------------------------------------------------------------------
// signal_phase_checker
// Watches the request, result and register ports of the signal controller,
// predicts the result fields for every accepted word and compares them in order.
// ----------------------------------------------------------------------------
module signal_phase_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [1:0] approach, [2] fixed_cycle_switch
   input  logic                          req_tuser,  // [0] operation
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [23:0]                   rsp_tdata,  // [5:0] major, [11:6] minor, [14:12] held,
                                                     // [15] serving, [17:16] movement
   input  logic                          csr_we,
   input  logic [asp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asp_pkg::TICK_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            awaiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import asp_pkg::*;
   import signal_phase_tb_pkg::*;

   localparam int RING_DEPTH = QUEUE_DEPTH_DEF;
   localparam int FIXED_STEPS = int'(FIXED_LAST) + 1;

   typedef enum logic [2:0] {
      SIG_IDLE,
      SIG_GREEN,
      SIG_YELLOW,
      SIG_CLEAR,
      SIG_GAP,
      SIG_FIXED
   } signal_phase_type;

   typedef struct packed {
      logic [LAMP_W-1:0] major;
      logic [LAMP_W-1:0] minor;
      logic [2:0]        held;
      logic              active;
      logic [MV_W-1:0]   movement;
   } lamp_report_type;

   // timing registers
   logic [TICK_W-1:0] green_default, extend_step, green_limit;
   logic [TICK_W-1:0] yellow_len, clear_len, gap_len;

   // controller state
   logic [MV_W-1:0]   ring [RING_DEPTH];
   int                head;
   int                held;
   signal_phase_type  phase;
   logic [TICK_W-1:0] timer;
   logic [TICK_W-1:0] green_len;
   logic [STEP_W-1:0] fixed_step;
   logic [LAMP_W-1:0] major_word, minor_word;

   lamp_report_type   lamp_reports[$];
   lamp_report_type   want;
   int                misses = 0;

   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

   function automatic void all_red();
      major_word = LAMP_RED;
      minor_word = LAMP_RED;
   endfunction

   function automatic void light_movement(input logic [MV_W-1:0] mv, input logic yellow);
      logic [LAMP_W-1:0] w;
      if (mv[0]) w = yellow ? LAMP_LEFT_YELLOW : LAMP_LEFT_GREEN;
      else w = yellow ? LAMP_FWD_YELLOW : LAMP_FWD_GREEN;
      all_red();
      if (mv[1]) minor_word = w;
      else major_word = w;
   endfunction

   // major road takes steps 1..5, minor road steps 7..11
   function automatic void light_fixed();
      int s;
      s = (int'(fixed_step) < FIXED_STEPS) ? int'(fixed_step) : 0;
      all_red();
      case (s)
         1:  major_word = LAMP_LEFT_GREEN;
         2:  major_word = LAMP_LEFT_YELLOW;
         4:  major_word = LAMP_FWD_GREEN;
         5:  major_word = LAMP_FWD_YELLOW;
         7:  minor_word = LAMP_LEFT_GREEN;
         8:  minor_word = LAMP_LEFT_YELLOW;
         10: minor_word = LAMP_FWD_GREEN;
         11: minor_word = LAMP_FWD_YELLOW;
         default: ;
      endcase
   endfunction

   function automatic logic [TICK_W-1:0] fixed_ticks(input logic [STEP_W-1:0] s);
      case (s)
         4'd1, 4'd4, 4'd7, 4'd10:        return 8'd10;
         4'd2, 4'd5, 4'd8, 4'd11, 4'd12: return 8'd2;
         default:                        return 8'd4;
      endcase
   endfunction

   function automatic void pick_cycle(input logic sw);
      timer = '0;
      if (sw) begin
         phase = SIG_FIXED;
         fixed_step = '0;
         light_fixed();
      end else if (held > 0) begin
         phase = SIG_GREEN;
         green_len = green_default;
         light_movement(ring[head], 1'b0);
      end else begin
         phase = SIG_IDLE;
         all_red();
      end
   endfunction

   function automatic logic is_serving();
      return phase == SIG_GREEN || phase == SIG_YELLOW || phase == SIG_CLEAR;
   endfunction

   function automatic void advance_signals(input signal_op_type op, input logic [MV_W-1:0] mv,
                                           input logic sw);
      int       i;
      logic     seen;
      logic [8:0] grown;
      if (op == OP_TICK) begin
         if (phase == SIG_IDLE) begin
            pick_cycle(sw);
         end else begin
            timer = timer + 1'b1;
            case (phase)
               SIG_GREEN: begin
                  if (timer >= at_least_one(green_len)) begin
                     phase = SIG_YELLOW;
                     timer = '0;
                     light_movement(ring[head], 1'b1);
                  end
               end
               SIG_YELLOW: begin
                  if (timer >= at_least_one(yellow_len)) begin
                     phase = SIG_CLEAR;
                     timer = '0;
                     all_red();
                  end
               end
               SIG_CLEAR: begin
                  if (timer >= at_least_one(clear_len)) begin
                     if (held > 0) begin
                        head = (head + 1) % RING_DEPTH;
                        held = held - 1;
                     end
                     timer = '0;
                     // a zero gap chooses the next cycle on this very tick
                     if (gap_len == '0) pick_cycle(sw);
                     else phase = SIG_GAP;
                  end
               end
               SIG_GAP: begin
                  if (timer >= gap_len) pick_cycle(sw);
               end
               default: begin
                  if (int'(fixed_step) >= FIXED_STEPS || timer >= fixed_ticks(fixed_step)) begin
                     fixed_step = fixed_step + 1'b1;
                     timer = '0;
                     if (int'(fixed_step) >= FIXED_STEPS) pick_cycle(sw);
                     else light_fixed();
                  end
               end
            endcase
         end
      end else begin
         // extend the green of the movement being served, saturating
         if (is_serving() && held > 0 && ring[head] == mv && green_len < green_limit) begin
            grown = {1'b0, green_len} + {1'b0, extend_step};
            green_len = grown[8] ? 8'hFF : grown[7:0];
         end
         seen = (held >= RING_DEPTH);
         for (i = 0; i < held; i++) begin
            if (ring[(head + i) % RING_DEPTH] == mv) seen = 1'b1;
         end
         if (!seen) begin
            ring[(head + held) % RING_DEPTH] = mv;
            held = held + 1;
         end
      end
   endfunction

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         misses++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         green_default = GREEN_DEFAULT_RST;
         extend_step = EXTEND_STEP_RST;
         green_limit = GREEN_LIMIT_RST;
         yellow_len = YELLOW_RST;
         clear_len = CLEARANCE_RST;
         gap_len = GAP_RST;
         foreach (ring[k]) ring[k] = '0;
         head = 0;
         held = 0;
         phase = SIG_IDLE;
         timer = '0;
         green_len = GREEN_DEFAULT_RST;
         fixed_step = '0;
         all_red();
         lamp_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GREEN_DEFAULT: green_default = csr_wdata;
               CSR_EXTEND_STEP:   extend_step = csr_wdata;
               CSR_GREEN_LIMIT:   green_limit = csr_wdata;
               CSR_YELLOW:        yellow_len = csr_wdata;
               CSR_CLEARANCE:     clear_len = csr_wdata;
               CSR_GAP:           gap_len = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (lamp_reports.size() == 0) begin
               $error("result word %h with nothing expected", rsp_tdata);
               misses++;
            end else begin
               want = lamp_reports.pop_front();
               check_field("major_lamps", int'(want.major), int'(rsp_tdata[5:0]));
               check_field("minor_lamps", int'(want.minor), int'(rsp_tdata[11:6]));
               check_field("pending_count", int'(want.held), int'(rsp_tdata[14:12]));
               check_field("serving_valid", int'(want.active), int'(rsp_tdata[15]));
               check_field("serving_approach", int'(want.movement),
                           int'(rsp_tdata[17:16]));
               check_field("padding", 0, int'(rsp_tdata[23:18]));
            end
         end
         if (req_tvalid && req_tready) begin
            advance_signals(signal_op_type'(req_tuser), req_tdata[1:0], req_tdata[2]);
            want.major = major_word;
            want.minor = minor_word;
            want.held = 3'(held);
            want.active = is_serving() && held > 0;
            want.movement = want.active ? ring[head] : '0;
            lamp_reports.push_back(want);
         end
      end
      awaiting <= lamp_reports.size();
      fail_count <= misses;
   end

endmodule

// ----- verif/actuated_signal_phase_controller_unit_test.sv -----
// ----------------------------------------------------------------------------
// actuated_signal_phase_controller_unit_test
// Drives ticks and detector requests into the signal controller under several
// timing settings, with random idle bursts on both channels, and leaves the
// prediction and comparison of every lamp word to the checker beside it.
// ----------------------------------------------------------------------------
module actuated_signal_phase_controller_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import asp_pkg::*;
   import signal_phase_tb_pkg::*;

   localparam int PHASE_WORDS = 155;
   localparam int PHASE_COUNT = 8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;  // [1:0] approach, [2] fixed_cycle_switch
   logic                 req_tuser = 1'b0; // [0] operation
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [23:0]          rsp_tdata;       // [5:0] major, [11:6] minor, [14:12] held,
                                          // [15] serving, [17:16] movement
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]    csr_wdata = '0;

   int fail_count;
   int awaiting;
   // chance in percent that either side starts an idle burst
   int stall_odds = 0;
   int rsp_hold = 0;

   actuated_signal_phase_controller_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   signal_phase_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .awaiting   (awaiting)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hold off the result side in random bursts, each starting at the deciding cycle.
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
         rsp_hold <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one word and return at the edge that takes it; valid stays high so
   // that back-to-back words need no second assignment in the same step.
   task automatic send_signal_word(input signal_op_type op, input movement_type mv,
                                   input logic sw);
      if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'b0, sw, mv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and wait until every lamp word predicted so far has come back.
   // The checker's count is registered, hence the first wait.
   task automatic drain_words();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   // Write all six timing registers on consecutive edges.
   task automatic load_timings(input logic [7:0] green, input logic [7:0] extend,
                               input logic [7:0] limit, input logic [7:0] yellow,
                               input logic [7:0] clear, input logic [7:0] gap);
      csr_we <= 1'b1;
      csr_index <= CSR_GREEN_DEFAULT;
      csr_wdata <= green;
      @(posedge clock);
      csr_index <= CSR_EXTEND_STEP;
      csr_wdata <= extend;
      @(posedge clock);
      csr_index <= CSR_GREEN_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_index <= CSR_YELLOW;
      csr_wdata <= yellow;
      @(posedge clock);
      csr_index <= CSR_CLEARANCE;
      csr_wdata <= clear;
      @(posedge clock);
      csr_index <= CSR_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly ticks so that phases run through; requests hit random movements,
   // and the switch is set on roughly one tick in eight.
   task automatic random_words(input int count, input bit calm);
      int            n;
      signal_op_type op;
      logic          sw;
      for (n = 0; n < count; n++) begin
         if (calm) begin
            stall_odds = 0;
         end else if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_odds = 0;
               1:       stall_odds = 15;
               default: stall_odds = 45;
            endcase
         end
         op = ($urandom_range(0, 9) < 6) ? OP_TICK : OP_REQUEST;
         sw = (op == OP_TICK) ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
         send_signal_word(op, movement_type'($urandom_range(0, 3)), sw);
      end
   endtask

   initial begin
      int p;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: short green with a low extension limit, zero gap
      stall_odds = 15;
      load_timings(8'd2, 8'd3, 8'd4, 8'd1, 8'd1, 8'd0);
      send_signal_word(OP_TICK, MV_MAJOR_FWD, 1'b0);     // idle, empty ring: all red
      send_signal_word(OP_REQUEST, MV_MAJOR_FWD, 1'b0);
      send_signal_word(OP_REQUEST, MV_MAJOR_LEFT, 1'b1);
      send_signal_word(OP_REQUEST, MV_MINOR_FWD, 1'b0);
      send_signal_word(OP_REQUEST, MV_MINOR_LEFT, 1'b0);
      send_signal_word(OP_REQUEST, MV_MAJOR_LEFT, 1'b0); // already held: dropped
      send_signal_word(OP_TICK, MV_MAJOR_FWD, 1'b0);     // green for major forward
      send_signal_word(OP_REQUEST, MV_MAJOR_FWD, 1'b0);  // extend below the limit
      send_signal_word(OP_REQUEST, MV_MAJOR_FWD, 1'b0);  // over the limit: no extension
      repeat (5) send_signal_word(OP_TICK, MV_MAJOR_FWD, 1'b0); // run out the green
      send_signal_word(OP_TICK, MV_MAJOR_FWD, 1'b0);     // yellow over, clearance
      send_signal_word(OP_TICK, MV_MAJOR_FWD, 1'b0);     // dequeue, next green at once
      send_signal_word(OP_TICK, MV_MINOR_LEFT, 1'b0);
      send_signal_word(OP_TICK, MV_MINOR_LEFT, 1'b0);
      send_signal_word(OP_TICK, MV_MINOR_LEFT, 1'b0);
      send_signal_word(OP_TICK, MV_MINOR_LEFT, 1'b1);    // switch set: fixed cycle
      send_signal_word(OP_REQUEST, MV_MINOR_FWD, 1'b0);  // already held while fixed runs: dropped
      send_signal_word(OP_TICK, MV_MINOR_FWD, 1'b1);
      send_signal_word(OP_TICK, MV_MINOR_FWD, 1'b0);
      drain_words();

      // Random phases, each under its own timings; the two slow ones come
      // last since a saturated green outlasts any single phase.
      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: load_timings(GREEN_DEFAULT_RST, EXTEND_STEP_RST, GREEN_LIMIT_RST,
                            YELLOW_RST, CLEARANCE_RST, GAP_RST);
            1: load_timings(8'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0);
            3: load_timings(8'd3, 8'd1, 8'd6, 8'd1, 8'd2, 8'd3);
            6: load_timings(8'd200, 8'd255, 8'd255, 8'd3, 8'd3, 8'd0);
            7: load_timings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
            default: load_timings(8'($urandom_range(1, 12)), 8'($urandom_range(0, 6)),
                                  8'($urandom_range(1, 30)), 8'($urandom_range(1, 4)),
                                  8'($urandom_range(1, 4)), 8'($urandom_range(0, 4)));
         endcase
         random_words(PHASE_WORDS, p == PHASE_COUNT - 1);
         drain_words();
      end

      // let any stray word show up before the verdict
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- actuated_signal_phase_controller_unit.f -----
rtl/core/asp_pkg.sv
rtl/core/asp_ram.sv
rtl/core/asp_alu.sv
rtl/core/actuated_signal_phase_controller_unit.sv
verif/signal_phase_tb_pkg.sv
verif/signal_phase_checker.sv
verif/actuated_signal_phase_controller_unit_test.sv
